// ===== src/console_cpu_bus_decoder_assert.svh =====
// Assertion macros for the CPU bus decoder.
// Included by console_cpu_bus_decoder, which checks its own logic; define NO_ASSERTIONS to drop them.
`ifndef CONSOLE_CPU_BUS_DECODER_ASSERT_SVH
`define CONSOLE_CPU_BUS_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/cbd_pkg.sv =====
// Shared types, address map constants and codes for the CPU bus decoder.
// No dependencies; imported by every module of the block but cbd_ram.
package cbd_pkg;

    localparam int RAM_DEPTH     = 2048;
    localparam int PROGRAM_DEPTH = 32768;
    localparam int RAM_AW        = $clog2(RAM_DEPTH);
    localparam int ROM_AW        = $clog2(PROGRAM_DEPTH);

    // bus modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // address map
    localparam logic [15:0] RAM_END    = 16'h2000;
    localparam logic [15:0] RAM_MIRROR = 16'h07FF;
    localparam logic [15:0] PPU_END    = 16'h4000;
    localparam logic [15:0] PPU_DECODE = 16'h2007;
    localparam logic [15:0] DMA_PORT   = 16'h4014;
    localparam logic [15:0] PAD_PORT   = 16'h4016;
    localparam logic [15:0] ROM_BASE   = 16'h8000;
    localparam logic [15:0] BANK_MASK  = 16'h3FFF;

    localparam logic [1:0] BANKS_ONE   = 2'd1;
    localparam logic [1:0] BANKS_RESET = 2'd2;
    localparam logic [3:0] PAD_BITS    = 4'd8;

    // configuration register indexes (word address)
    localparam logic REG_PROGRAM_BANKS = 1'b0;

    // source of the read data byte
    typedef logic [1:0] t_src;
    localparam t_src SRC_NONE = 2'd0;
    localparam t_src SRC_RAM  = 2'd1;
    localparam t_src SRC_ROM  = 2'd2;
    localparam t_src SRC_PAD  = 2'd3;

    typedef logic [RAM_AW-1:0] t_ram_addr;
    typedef logic [ROM_AW-1:0] t_rom_addr;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  buttons;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ppu_access;
        logic [2:0] ppu_register;
        logic       ppu_is_write;
        logic [7:0] ppu_write_data;
        logic       dma_start;
        logic [7:0] dma_page;
    } t_out_item;

    // decoded access: memory controls plus the fields that need no memory
    typedef struct packed {
        logic       ram_we;
        logic       ram_re;
        t_ram_addr  ram_addr;
        logic       rom_we;
        logic       rom_re;
        t_rom_addr  rom_addr;
        logic       pad_read;
        logic       pad_load;
        t_src       src;
        logic       ppu_access;
        logic [2:0] ppu_register;
        logic       ppu_is_write;
        logic [7:0] ppu_write_data;
        logic       dma_start;
        logic [7:0] dma_page;
    } t_dec;

    // item held while its memory read completes
    typedef struct packed {
        t_src       src;
        logic       pad_bit;
        logic       ppu_access;
        logic [2:0] ppu_register;
        logic       ppu_is_write;
        logic [7:0] ppu_write_data;
        logic       dma_start;
        logic [7:0] dma_page;
    } t_stage;

endpackage

// ===== src/console_cpu_bus_decoder.sv =====
// CPU bus decoder for a console memory map.
// Input channel: one bus access per beat (mode, address, write_data, buttons), taken
// when i_in_valid is high and o_in_stall low. Output channel: one result beat per
// input beat, in order, taken when o_out_valid is high and i_out_stall low.
// A result passes the synchronous RAM/ROM read, held in the read stage, and then the
// output register. Throughput is one beat per cycle while the receiver does not stall,
// set by the single port of each memory (a read or a write per beat).
// While the output register holds an untaken result, one more item is taken into
// the read stage; further input is stalled until the receiver takes the result.
// Reset (i_rst_n low, synchronous) empties both stages, clears the controller
// latch and bit count and sets program_banks to 2. RAM and program ROM contents
// are not cleared and read as undefined until written; load mode fills the ROM.
// program_banks sits at byte address 0 of the APB port; write it only while idle.
// Depends on cbd_pkg, cbd_decode, cbd_ram and the assertion header.
`include "console_cpu_bus_decoder_assert.svh"
module console_cpu_bus_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cbd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cbd_pkg::t_out_item  o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import cbd_pkg::*;

    t_dec       dec;
    logic       in_acc;
    logic       s1_adv;
    logic       cfg_wr;
    logic       cfg_idx;
    logic [7:0] ram_q;
    logic [7:0] rom_q;
    logic       pad_bit;

    logic [1:0] r_program_banks;
    logic [7:0] r_pad_latch;
    logic [3:0] r_pad_count;
    logic [3:0] n_pad_count;
    logic       r_s1_valid;
    t_stage     r_s1;
    t_stage     n_s1;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];
    assign prdata  = (cfg_idx == REG_PROGRAM_BANKS) ? 32'(r_program_banks) : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_banks <= BANKS_RESET;
        end else if (cfg_wr && cfg_idx == REG_PROGRAM_BANKS) begin
            r_program_banks <= pwdata[1:0];
        end
    end

    cbd_decode u_decode (
        .i_item          (i_in_item),
        .i_program_banks (r_program_banks),
        .o_dec           (dec)
    );

    // handshake: the read stage moves on when the output register is free or taken
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    cbd_ram #(.DEPTH(RAM_DEPTH), .WIDTH(8)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && dec.ram_we),
        .i_re    (in_acc && dec.ram_re),
        .i_addr  (dec.ram_addr),
        .i_wdata (i_in_item.write_data),
        .o_rdata (ram_q)
    );

    cbd_ram #(.DEPTH(PROGRAM_DEPTH), .WIDTH(8)) u_program_rom (
        .i_clk   (i_clk),
        .i_we    (in_acc && dec.rom_we),
        .i_re    (in_acc && dec.rom_re),
        .i_addr  (dec.rom_addr),
        .i_wdata (i_in_item.write_data),
        .o_rdata (rom_q)
    );

    // controller port: shift out one button bit per read, saturate at eight
    always_comb begin
        pad_bit     = 1'b0;
        n_pad_count = r_pad_count;
        if (dec.pad_read && r_pad_count < PAD_BITS) begin
            pad_bit     = r_pad_latch[r_pad_count[2:0]];
            n_pad_count = r_pad_count + 4'd1;
        end
        if (dec.pad_load) begin
            n_pad_count = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_latch <= 8'h00;
            r_pad_count <= 4'd0;
        end else if (in_acc) begin
            r_pad_count <= n_pad_count;
            if (dec.pad_load) begin
                r_pad_latch <= i_in_item.buttons;
            end
        end
    end

    always_comb begin
        n_s1.src            = dec.src;
        n_s1.pad_bit        = pad_bit;
        n_s1.ppu_access     = dec.ppu_access;
        n_s1.ppu_register   = dec.ppu_register;
        n_s1.ppu_is_write   = dec.ppu_is_write;
        n_s1.ppu_write_data = dec.ppu_write_data;
        n_s1.dma_start      = dec.dma_start;
        n_s1.dma_page       = dec.dma_page;
    end

    // read stage: payload beside the memory read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        case (r_s1.src)
            SRC_RAM: n_out.read_data = ram_q;
            SRC_ROM: n_out.read_data = rom_q;
            SRC_PAD: n_out.read_data = {7'd0, r_s1.pad_bit};
            default: n_out.read_data = 8'h00;
        endcase
        n_out.ppu_access     = r_s1.ppu_access;
        n_out.ppu_register   = r_s1.ppu_register;
        n_out.ppu_is_write   = r_s1.ppu_is_write;
        n_out.ppu_write_data = r_s1.ppu_write_data;
        n_out.dma_start      = r_s1.dma_start;
        n_out.dma_page       = r_s1.dma_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `CBD_ASSERT(a_pad_count_sat, i_clk, i_rst_n, r_pad_count <= PAD_BITS, "pad count past eight")
    `CBD_ASSERT(a_pad_load_clear, i_clk, i_rst_n, (in_acc && dec.pad_load) |=> (r_pad_count == 4'd0), "pad count not cleared")
    `CBD_ASSERT(a_one_mem_write, i_clk, i_rst_n, !(dec.ram_we && dec.rom_we), "RAM and ROM written by one beat")
    `CBD_ASSERT(a_s1_hold, i_clk, i_rst_n, (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1)), "read stage lost while output stalled")
    `CBD_ASSERT(a_out_exclusive, i_clk, i_rst_n, o_out_valid |-> !(o_out_item.dma_start && o_out_item.ppu_access), "DMA and picture-unit access together")

endmodule

// ===== src/cbd_ram.sv =====
// Single-port synchronous memory with registered read data.
// Generic; no package dependency.
module cbd_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // hold the last read while no new read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cbd_decode.sv =====
// Address decode for one bus access: memory, picture-unit, DMA and controller-port fields.
// Depends on cbd_pkg.
module cbd_decode (
    input  cbd_pkg::t_in_item i_item,
    input  logic [1:0]        i_program_banks,
    output cbd_pkg::t_dec     o_dec
);
    import cbd_pkg::*;

    logic        in_ram;
    logic        in_ppu;
    logic        in_rom;
    logic [15:0] rom_off;
    logic [15:0] ppu_sel;
    t_rom_addr   rom_rd_addr;
    t_rom_addr   rom_ld_addr;

    always_comb begin
        in_rom  = i_item.address >= ROM_BASE;
        in_ram  = i_item.address < RAM_END;
        in_ppu  = !in_ram && (i_item.address < PPU_END);
        ppu_sel = i_item.address & PPU_DECODE;

        rom_off = i_item.address - ROM_BASE;
        if (i_program_banks == BANKS_ONE) begin
            rom_off = rom_off & BANK_MASK;
        end
        rom_rd_addr = t_rom_addr'(rom_off % PROGRAM_DEPTH);
        rom_ld_addr = t_rom_addr'(i_item.address % PROGRAM_DEPTH);

        o_dec                = '0;
        o_dec.ram_addr       = t_ram_addr'((i_item.address & RAM_MIRROR) % RAM_DEPTH);
        o_dec.rom_addr       = rom_rd_addr;
        o_dec.src            = SRC_NONE;

        case (i_item.mode)
            MODE_LOAD: begin
                o_dec.rom_we   = 1'b1;
                o_dec.rom_addr = rom_ld_addr;
            end
            MODE_READ: begin
                if (in_rom) begin
                    o_dec.rom_re = 1'b1;
                    o_dec.src    = SRC_ROM;
                end else if (in_ram) begin
                    o_dec.ram_re = 1'b1;
                    o_dec.src    = SRC_RAM;
                end else if (in_ppu) begin
                    o_dec.ppu_access   = 1'b1;
                    o_dec.ppu_register = ppu_sel[2:0];
                end else if (i_item.address == PAD_PORT) begin
                    o_dec.pad_read = 1'b1;
                    o_dec.src      = SRC_PAD;
                end
            end
            MODE_WRITE: begin
                if (in_ram) begin
                    o_dec.ram_we = 1'b1;
                end else if (in_ppu) begin
                    o_dec.ppu_access     = 1'b1;
                    o_dec.ppu_register   = ppu_sel[2:0];
                    o_dec.ppu_is_write   = 1'b1;
                    o_dec.ppu_write_data = i_item.write_data;
                end else if (i_item.address == DMA_PORT) begin
                    o_dec.dma_start = 1'b1;
                    o_dec.dma_page  = i_item.write_data;
                end else if (i_item.address == PAD_PORT && i_item.write_data == 8'h00) begin
                    o_dec.pad_load = 1'b1;
                end
            end
            default: begin
                // unused mode: no access, all-zero result
                o_dec.src = SRC_NONE;
            end
        endcase
    end

endmodule

// ===== verif/bus_decode_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the CPU bus decoder: follows the configuration port and both beat
// channels, predicts each result and compares it. Depends on cbd_pkg only.
module bus_decode_checker #(
    parameter logic [2:0] BANKS_ADDR = 3'd0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  cbd_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  cbd_pkg::t_out_item  i_out_item,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    input  logic                i_pready,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked
);
    import cbd_pkg::*;

    logic [7:0] ram_image [RAM_DEPTH];
    logic [7:0] rom_image [PROGRAM_DEPTH];
    logic [7:0] pad_shift;
    logic [3:0] pad_count;
    logic [1:0] bank_setting;

    t_out_item awaited_results [$];
    int        err_count = 0;
    int        shown     = 0;
    int        checked   = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic t_out_item decode_access(t_in_item beat);
        t_out_item   r;
        logic [15:0] off;
        logic [15:0] reg_sel;
        r = '0;
        case (beat.mode)
            MODE_LOAD: begin
                rom_image[int'(beat.address) % PROGRAM_DEPTH] = beat.write_data;
            end
            MODE_READ: begin
                if (beat.address >= ROM_BASE) begin
                    off = beat.address - ROM_BASE;
                    if (bank_setting == BANKS_ONE) off &= BANK_MASK;
                    r.read_data = rom_image[int'(off) % PROGRAM_DEPTH];
                end else if (beat.address < RAM_END) begin
                    r.read_data = ram_image[int'(beat.address & RAM_MIRROR) % RAM_DEPTH];
                end else if (beat.address < PPU_END) begin
                    reg_sel = beat.address & PPU_DECODE;
                    r.ppu_access   = 1'b1;
                    r.ppu_register = reg_sel[2:0];
                end else if (beat.address == PAD_PORT) begin
                    // shift out the next button; hold at eight once all are gone
                    if (pad_count < PAD_BITS) begin
                        r.read_data = {7'd0, pad_shift[pad_count[2:0]]};
                        pad_count++;
                    end
                end
            end
            MODE_WRITE: begin
                if (beat.address < RAM_END) begin
                    ram_image[int'(beat.address & RAM_MIRROR) % RAM_DEPTH] = beat.write_data;
                end else if (beat.address < PPU_END) begin
                    reg_sel = beat.address & PPU_DECODE;
                    r.ppu_access     = 1'b1;
                    r.ppu_register   = reg_sel[2:0];
                    r.ppu_is_write   = 1'b1;
                    r.ppu_write_data = beat.write_data;
                end else if (beat.address == DMA_PORT) begin
                    r.dma_start = 1'b1;
                    r.dma_page  = beat.write_data;
                end else if (beat.address == PAD_PORT && beat.write_data == 8'd0) begin
                    pad_shift = beat.buttons;
                    pad_count = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            awaited_results.delete();
            bank_setting = BANKS_RESET;
            pad_shift    = '0;
            pad_count    = '0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BANKS_ADDR)
                bank_setting = i_pwdata[1:0];
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (awaited_results.size() == 0) begin
                    err_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("[%0t] result beat with nothing awaited: %p", $realtime, got);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (got.read_data !== want.read_data
                        || got.ppu_access !== want.ppu_access
                        || got.ppu_register !== want.ppu_register
                        || got.ppu_is_write !== want.ppu_is_write
                        || got.ppu_write_data !== want.ppu_write_data
                        || got.dma_start !== want.dma_start
                        || got.dma_page !== want.dma_page) begin
                        err_count++;
                        if (shown < 10) begin
                            shown++;
                            $display("[%0t] result %0d mismatch", $realtime, checked);
                            $display("    expected rd=%02h ppu=%b reg=%0d wr=%b wd=%02h dma=%b pg=%02h",
                                     want.read_data, want.ppu_access, want.ppu_register,
                                     want.ppu_is_write, want.ppu_write_data, want.dma_start,
                                     want.dma_page);
                            $display("    actual   rd=%02h ppu=%b reg=%0d wr=%b wd=%02h dma=%b pg=%02h",
                                     got.read_data, got.ppu_access, got.ppu_register,
                                     got.ppu_is_write, got.ppu_write_data, got.dma_start,
                                     got.dma_page);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(decode_access(i_in_item));
        end
        o_errors  <= err_count;
        o_pending <= awaited_results.size();
        o_checked <= checked;
    end

endmodule

// ===== verif/console_cpu_bus_decoder_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for console_cpu_bus_decoder: clock, reset, bus access stimulus, receiver
// stalls and the verdict. Depends on cbd_pkg, the block and bus_decode_checker.
module console_cpu_bus_decoder_tb;
    import cbd_pkg::*;

    localparam logic [1:0] MODE_SPARE     = 2'd3;
    localparam logic [2:0] BANKS_ADDR     = {REG_PROGRAM_BANKS, 2'b00};
    localparam int         PHASE_BEATS    = 200;
    localparam int         PHASES         = 6;
    localparam int         LONG_HOLD      = 80;
    localparam int         SETTLE         = 6;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int checked;

    bit ram_written [RAM_DEPTH];
    bit rom_written [PROGRAM_DEPTH];
    logic [1:0] bank_now = BANKS_RESET;

    int  beats_sent   = 0;
    int  useful_beats = 0;
    int  n_reads      = 0;
    int  n_writes     = 0;
    int  n_loads      = 0;
    int  n_spare      = 0;
    int  n_pad_reads  = 0;
    int  burst_left   = 0;
    bit  send_quiet   = 0;
    int  hold_asks    = 0;
    int  hold_served  = 0;
    bit  out_taken    = 0;
    int  idle_cycles  = 0;

    console_cpu_bus_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bus_decode_checker #(.BANKS_ADDR(BANKS_ADDR)) decode_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver: per-result stall draw, plus a long hold-off when stimulus asks for one
    always @(posedge i_clk) out_taken <= o_out_valid && !i_out_stall;

    initial begin : receiver
        int stall_left;
        int hold_left;
        int results_seen;
        bit recv_quiet;
        stall_left   = 0;
        hold_left    = 0;
        results_seen = 0;
        recv_quiet   = 0;
        i_out_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_served) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (out_taken) begin
                results_seen++;
                if (results_seen % 50 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
                stall_left = recv_quiet ? 0 : $urandom_range(0, 14);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results awaited",
                         WATCHDOG_LIMIT, pending);
                $display("console_cpu_bus_decoder_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic int ram_slot(logic [15:0] addr);
        return int'(addr & RAM_MIRROR) % RAM_DEPTH;
    endfunction

    function automatic int rom_slot(logic [15:0] addr);
        logic [15:0] off;
        off = addr - ROM_BASE;
        if (bank_now == BANKS_ONE) off &= BANK_MASK;
        return int'(off) % PROGRAM_DEPTH;
    endfunction

    // mostly a few narrow windows so that reads find written entries
    function automatic logic [14:0] rom_pick();
        if ($urandom_range(0, 3) != 0)
            return 15'($urandom_range(0, 3) << 13) | 15'($urandom_range(0, 15));
        return 15'($urandom_range(0, PROGRAM_DEPTH - 1));
    endfunction

    // any of the four RAM mirrors
    function automatic logic [15:0] ram_pick();
        logic [10:0] slot;
        if ($urandom_range(0, 9) < 7)
            slot = ($urandom_range(0, 1) ? 11'h000 : 11'h7E0) | 11'($urandom_range(0, 31));
        else
            slot = 11'($urandom_range(0, RAM_DEPTH - 1));
        return {3'b000, 2'($urandom_range(0, 3)), slot};
    endfunction

    task automatic put_beat(input logic [1:0] mode, input logic [15:0] addr,
                            input logic [7:0] data, input bit counts);
        int       gap;
        t_in_item beat;
        beat.mode       = mode;
        beat.address    = addr;
        beat.write_data = data;
        beat.buttons    = 8'($urandom_range(0, 255));
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = send_quiet ? 0 : $urandom_range(0, 14);
        end
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= beat;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        beats_sent++;
        if (counts) useful_beats++;
        if (beats_sent % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        case (mode)
            MODE_READ: begin
                n_reads++;
                if (addr == PAD_PORT) n_pad_reads++;
            end
            MODE_WRITE: begin
                n_writes++;
                if (addr < RAM_END) ram_written[ram_slot(addr)] = 1'b1;
            end
            MODE_LOAD: begin
                n_loads++;
                rom_written[int'(addr) % PROGRAM_DEPTH] = 1'b1;
            end
            default: n_spare++;
        endcase
    endtask

    // never read an entry that has not been written: fill it first instead
    task automatic read_or_fill(input logic [15:0] addr);
        logic [7:0] data;
        data = 8'($urandom_range(0, 255));
        if (addr < RAM_END && !ram_written[ram_slot(addr)])
            put_beat(MODE_WRITE, addr, data, 1'b1);
        else if (addr >= ROM_BASE && !rom_written[rom_slot(addr)])
            put_beat(MODE_LOAD, {1'($urandom_range(0, 1)), 15'(rom_slot(addr))}, data, 1'b1);
        else
            put_beat(MODE_READ, addr, data, 1'b1);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_banks(input logic [1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BANKS_ADDR;
        pwdata  <= {30'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bank_now = value;
    endtask

    initial begin : stimulus
        int         ph;
        int         pick;
        int         phase_end;
        bit         held;
        logic [1:0] mode;
        logic [1:0] setting;
        logic [7:0] data;
        logic [15:0] addr;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: store ends, mirrors, picture-unit, DMA, controller and unused mode
        put_beat(MODE_LOAD, 16'h0000, 8'hA5, 1'b1);
        put_beat(MODE_LOAD, 16'hFFFF, 8'h5A, 1'b1);
        put_beat(MODE_LOAD, 16'h4000, 8'h3C, 1'b1);
        put_beat(MODE_WRITE, ROM_BASE, 8'h11, 1'b0);
        put_beat(MODE_READ, ROM_BASE, 8'h00, 1'b1);
        put_beat(MODE_READ, 16'hFFFF, 8'hFF, 1'b1);
        put_beat(MODE_READ, 16'hC000, 8'h00, 1'b1);
        put_beat(MODE_WRITE, 16'h0000, 8'hFF, 1'b1);
        put_beat(MODE_WRITE, 16'h1FFF, 8'h00, 1'b1);
        put_beat(MODE_READ, 16'h1800, 8'h00, 1'b1);
        put_beat(MODE_WRITE, RAM_END, 8'h81, 1'b1);
        put_beat(MODE_READ, PPU_END - 16'd1, 8'h00, 1'b1);
        put_beat(MODE_WRITE, DMA_PORT, 8'hFF, 1'b1);
        put_beat(MODE_READ, DMA_PORT, 8'h00, 1'b0);
        put_beat(MODE_SPARE, 16'hFFFF, 8'hFF, 1'b0);
        put_beat(MODE_WRITE, PAD_PORT, 8'h00, 1'b1);
        repeat (9) put_beat(MODE_READ, PAD_PORT, 8'h00, 1'b1);
        put_beat(MODE_WRITE, PAD_PORT, 8'h01, 1'b0);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       setting = BANKS_RESET;
                1:       setting = BANKS_ONE;
                2:       setting = 2'd3;
                3:       setting = 2'd0;
                4:       setting = BANKS_RESET;
                default: setting = BANKS_ONE;
            endcase
            settle();
            write_banks(setting);
            held      = 1'b0;
            phase_end = useful_beats + PHASE_BEATS;
            while (useful_beats < phase_end) begin
                if (!held && useful_beats >= phase_end - PHASE_BEATS / 2) begin
                    // starve the output while input keeps coming, to fill the block
                    held = 1'b1;
                    hold_asks++;
                    burst_left = 40;
                end
                pick = $urandom_range(0, 99);
                data = 8'($urandom_range(0, 255));
                if (pick < 12) begin
                    if ($urandom_range(0, 4) == 0)
                        put_beat(MODE_WRITE, PAD_PORT, data, data == 8'd0);
                    else
                        put_beat(MODE_WRITE, PAD_PORT, 8'd0, 1'b1);
                    repeat ($urandom_range(1, 10))
                        put_beat(MODE_READ, PAD_PORT, 8'($urandom_range(0, 255)), 1'b1);
                end else if (pick < 28) begin
                    put_beat(MODE_WRITE, ram_pick(), data, 1'b1);
                end else if (pick < 42) begin
                    read_or_fill(ram_pick());
                end else if (pick < 52) begin
                    put_beat(MODE_LOAD, {1'($urandom_range(0, 1)), rom_pick()}, data, 1'b1);
                end else if (pick < 66) begin
                    read_or_fill({1'b1, rom_pick()});
                end else if (pick < 76) begin
                    mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
                    put_beat(mode, {3'b001, 13'($urandom_range(0, 8191))}, data, 1'b1);
                end else if (pick < 81) begin
                    put_beat(MODE_WRITE, DMA_PORT, data, 1'b1);
                end else if (pick < 85) begin
                    mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
                    put_beat(mode, PPU_END + 16'($urandom_range(0, 16'h3FFF)), data, 1'b0);
                end else if (pick < 90) begin
                    put_beat(MODE_WRITE, ROM_BASE | 16'($urandom_range(0, 16'h7FFF)), data,
                             1'b0);
                end else if (pick < 94) begin
                    put_beat(MODE_SPARE, 16'($urandom_range(0, 65535)), data, 1'b0);
                end else begin
                    mode = 2'($urandom_range(0, 3));
                    addr = 16'($urandom_range(0, 65535));
                    if (mode == MODE_READ)
                        read_or_fill(addr);
                    else
                        put_beat(mode, addr, data, mode != MODE_SPARE);
                end
            end
        end

        settle();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d beats: %0d reads (%0d controller), %0d writes, %0d loads, %0d unused",
                 beats_sent, n_reads, n_pad_reads, n_writes, n_loads, n_spare);
        $display("%0d results compared over %0d bank settings with %0d output hold-offs",
                 checked, PHASES, hold_served);
        if (errors == 0 && pending == 0)
            $display("console_cpu_bus_decoder_tb OK");
        else
            $display("console_cpu_bus_decoder_tb NOT OK");
        $finish;
    end

endmodule
